>>> hdl/jbs_pkg.sv
package jbs_pkg;

  typedef logic signed [23:0] cell_t;
  typedef logic [11:0] idx_t;

  typedef struct packed {
    cell_t above;
    cell_t mid;
    cell_t below;
  } column_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  typedef struct packed {
    column_t left;
    column_t mid;
    column_t right;
    cell_t   old;
    div_t    div;
    idx_t    row;
    idx_t    col;
    logic    frame_end;
    logic    last_of_run;
  } req_t;

  localparam logic CFG_GRID_SIZE = 1'b0;
  localparam logic CFG_TARGET    = 1'b1;

  localparam logic [11:0] GRID_RESET   = 12'd2048;
  localparam logic [23:0] TARGET_RESET = 24'd3277;
  localparam logic [11:0] GRID_MIN     = 12'd3;

  localparam int          RECIP_SHIFT = 31;
  localparam logic [28:0] RECIP_9     = 29'd238609294;
  localparam logic [28:0] RECIP_6     = 29'd357913941;

endpackage

>>> hdl/jacobi_box_average_sweep.sv
// One Jacobi box-average sweep over a square grid that arrives one signed Q8.16 cell per
// transfer in row-major order. Two rows of old cells live in a single-port-per-side line
// memory of MAX_SIZE entries, read when a cell is taken and written back as it moves on.
// It takes one cell per cycle when not stalled; each cell causes zero to four results,
// one per cycle from a four-stage arithmetic pipeline while out_stall is low; row-end and
// last-row cells stall input as results issue. Writing grid_size restarts the sweep.

module jacobi_box_average_sweep #(
  parameter int MAX_SIZE = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] cell_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        row_index,
  output logic [10:0]        column_index,
  output logic signed [23:0] new_value,
  output logic [23:0]        abs_change,
  output logic [23:0]        frame_max_change,
  output logic               converged,
  output logic               frame_end,
  output logic               last_of_run
);

  localparam int CW = $clog2(MAX_SIZE);

  logic [11:0]      grid_size;
  logic [23:0]      target_change;
  logic [CW-1:0]    row;
  logic [CW-1:0]    col;
  jbs_pkg::idx_t    last_idx;
  logic             in_acc;
  logic             cfg_acc;
  logic             grid_wr;
  logic             row_last;
  logic             col_last;

  logic             s1_valid;
  jbs_pkg::cell_t   s1_cell;
  jbs_pkg::idx_t    s1_row;
  jbs_pkg::idx_t    s1_col;
  logic [CW-1:0]    s1_addr;
  logic [3:0]       s1_mask;
  logic             s1_go;
  logic [47:0]      rd_data;
  jbs_pkg::column_t cur;

  logic             load_ok;
  logic             req_valid;
  jbs_pkg::req_t    req;
  logic             en;

  assign cfg_ready = 1'b1;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign grid_wr = cfg_acc && (cfg_index == jbs_pkg::CFG_GRID_SIZE);

  always_comb begin
    if (grid_size < jbs_pkg::GRID_MIN) last_idx = jbs_pkg::GRID_MIN - 12'd1;
    else if (int'(grid_size) > MAX_SIZE) last_idx = 12'(MAX_SIZE - 1);
    else last_idx = grid_size - 12'd1;
  end

  assign row_last = (12'(row) == last_idx);
  assign col_last = (12'(col) == last_idx);
  assign in_stall = s1_valid && !load_ok;
  assign in_acc = in_valid && !in_stall;
  assign s1_go = s1_valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= jbs_pkg::GRID_RESET;
      target_change <= jbs_pkg::TARGET_RESET;
      row <= '0;
      col <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
        if (col_last) begin
          col <= '0;
          row <= row_last ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (cfg_acc) begin
        if (cfg_index == jbs_pkg::CFG_GRID_SIZE) begin
          grid_size <= cfg_data[11:0];
          row <= '0;
          col <= '0;
        end else begin
          target_change <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cell <= cell_value;
      s1_row <= 12'(row);
      s1_col <= 12'(col);
      s1_addr <= col;
      s1_mask <= {row_last && col_last, row_last && (col != '0),
                  (row != '0) && col_last, (row != '0) && (col != '0)};
    end
  end

  assign cur = '{rd_data[47:24], rd_data[23:0], s1_cell};

  jbs_line_mem #(
    .DEPTH(MAX_SIZE),
    .AW(CW)
  ) u_mem (
    .clk(clk),
    .rd_en(in_acc),
    .rd_addr(col),
    .rd_data(rd_data),
    .wr_en(s1_go),
    .wr_addr(s1_addr),
    .wr_data({rd_data[23:0], s1_cell})
  );

  jbs_window u_window (
    .clk(clk),
    .rst(rst),
    .load(s1_go),
    .cur(cur),
    .mask(s1_mask),
    .row(s1_row),
    .col(s1_col),
    .last_idx(last_idx),
    .en(en),
    .load_ok(load_ok),
    .req_valid(req_valid),
    .req(req)
  );

  jbs_avg_pipe u_pipe (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req(req),
    .target(target_change),
    .clear_max(grid_wr),
    .en(en),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_index(row_index),
    .column_index(column_index),
    .new_value(new_value),
    .abs_change(abs_change),
    .frame_max_change(frame_max_change),
    .converged(converged),
    .frame_end(frame_end),
    .last_of_run(last_of_run)
  );

  a_conv_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && converged |-> frame_end)
    else $error("converged flagged on a result that is not the last cell");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> abs_change <= frame_max_change)
    else $error("frame maximum below the change of its own result");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted cell did not reach the memory read stage");

endmodule

>>> hdl/jbs_line_mem.sv
module jbs_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [47:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [47:0]   wr_data
);

  logic [47:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/jbs_window.sv
module jbs_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jbs_pkg::column_t  cur,
  input  logic [3:0]        mask,
  input  jbs_pkg::idx_t     row,
  input  jbs_pkg::idx_t     col,
  input  jbs_pkg::idx_t     last_idx,
  input  logic              en,
  output logic              load_ok,
  output logic              req_valid,
  output jbs_pkg::req_t     req
);

  jbs_pkg::cell_t   win [6];
  jbs_pkg::cell_t   jwin [6];
  jbs_pkg::column_t jcur;
  logic [3:0]       jmask;
  jbs_pkg::idx_t    jrow;
  jbs_pkg::idx_t    jcol;
  logic [3:0]       jmask_next;

  assign req_valid = (jmask != 4'd0);
  assign load_ok = (jmask == 4'd0) || (en && $onehot(jmask));

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        win[i] <= win[i+3];
      end
      win[3] <= cur.above;
      win[4] <= cur.mid;
      win[5] <= cur.below;
      for (int i = 0; i < 6; i++) begin
        jwin[i] <= win[i];
      end
      jcur <= cur;
      jrow <= row;
      jcol <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jmask <= 4'd0;
    end else if (load) begin
      jmask <= mask;
    end else if (en) begin
      jmask <= jmask_next;
    end
  end

  always_comb begin
    jbs_pkg::column_t l, m, r;
    jbs_pkg::idx_t    rr, cc;
    logic             up, down, lf, rt, pass;
    logic [1:0]       missing;
    l = '0;
    m = '0;
    r = '0;
    rr = jrow;
    cc = jcol;
    jmask_next = jmask;
    if (jmask[0]) begin
      jmask_next[0] = 1'b0;
      rr = jrow - 12'd1;
      cc = jcol - 12'd1;
      l = '{jwin[0], jwin[1], jwin[2]};
      m = '{jwin[3], jwin[4], jwin[5]};
      r = jcur;
    end else if (jmask[1]) begin
      jmask_next[1] = 1'b0;
      rr = jrow - 12'd1;
      l = '{jwin[3], jwin[4], jwin[5]};
      m = jcur;
    end else if (jmask[2]) begin
      jmask_next[2] = 1'b0;
      cc = jcol - 12'd1;
      l = '{jwin[1], jwin[2], 24'sd0};
      m = '{jwin[4], jwin[5], 24'sd0};
      r = '{jcur.mid, jcur.below, 24'sd0};
    end else begin
      jmask_next[3] = 1'b0;
      l = '{jwin[4], jwin[5], 24'sd0};
      m = '{jcur.mid, jcur.below, 24'sd0};
    end
    up = (rr != 12'd0);
    down = (rr != last_idx);
    lf = (cc != 12'd0);
    rt = (cc != last_idx);
    pass = (!up && !lf) || (!down && !rt);
    missing = 2'(!up) + 2'(!down) + 2'(!lf) + 2'(!rt);
    if (!lf) l = '0;
    if (!rt) r = '0;
    if (!up) begin
      l.above = '0;
      m.above = '0;
      r.above = '0;
    end
    if (!down) begin
      l.below = '0;
      m.below = '0;
      r.below = '0;
    end
    req.left = l;
    req.mid = m;
    req.right = r;
    req.old = m.mid;
    if (pass) req.div = jbs_pkg::DIV_NONE;
    else if (missing == 2'd0) req.div = jbs_pkg::DIV_9;
    else if (missing == 2'd1) req.div = jbs_pkg::DIV_6;
    else req.div = jbs_pkg::DIV_4;
    req.row = rr;
    req.col = cc;
    req.frame_end = !down && !rt;
    req.last_of_run = (jmask_next == 4'd0);
  end

endmodule

>>> hdl/jbs_avg_pipe.sv
module jbs_avg_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  jbs_pkg::req_t         req,
  input  logic [23:0]           target,
  input  logic                  clear_max,
  output logic                  en,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [10:0]           row_index,
  output logic [10:0]           column_index,
  output logic signed [23:0]    new_value,
  output logic [23:0]           abs_change,
  output logic [23:0]           frame_max_change,
  output logic                  converged,
  output logic                  frame_end,
  output logic                  last_of_run
);

  typedef struct packed {
    jbs_pkg::cell_t old;
    jbs_pkg::div_t  div;
    jbs_pkg::idx_t  row;
    jbs_pkg::idx_t  col;
    logic           frame_end;
    logic           last_of_run;
  } tag_t;

  logic              v1, v2, v3;
  tag_t              t1, t2, t3;
  logic signed [27:0] sum1;
  logic [26:0]       mag2;
  logic              neg2;
  logic [55:0]       prod2;
  jbs_pkg::cell_t    nv3;
  logic [23:0]       run_max;

  logic signed [27:0] sum_c;
  logic [26:0]        mag_c;
  logic [28:0]        recip_c;
  logic [23:0]        q_c;
  logic [27:0]        qd_c;
  logic [27:0]        rem_c;
  logic [4:0]         d_c;
  jbs_pkg::cell_t     nv_c;
  logic signed [24:0] diff_c;
  logic [23:0]        ad_c;
  logic [23:0]        mx_c;

  assign en = !out_valid || !out_stall;

  always_comb begin
    sum_c = 28'(req.left.above) + 28'(req.left.mid) + 28'(req.left.below)
          + 28'(req.mid.above) + 28'(req.mid.mid) + 28'(req.mid.below)
          + 28'(req.right.above) + 28'(req.right.mid) + 28'(req.right.below);
  end

  always_comb begin
    logic [27:0] a;
    a = sum1[27] ? 28'(-sum1) : 28'(sum1);
    case (t1.div)
      jbs_pkg::DIV_9: begin
        mag_c = 27'(a + 28'd4);
        recip_c = jbs_pkg::RECIP_9;
      end
      jbs_pkg::DIV_6: begin
        mag_c = 27'(a + 28'd3);
        recip_c = jbs_pkg::RECIP_6;
      end
      default: begin
        mag_c = 27'(a + 28'd2);
        recip_c = '0;
      end
    endcase
  end

  always_comb begin
    q_c = prod2[jbs_pkg::RECIP_SHIFT +: 24];
    case (t2.div)
      jbs_pkg::DIV_9: begin
        d_c = 5'd9;
        qd_c = {1'b0, q_c, 3'b0} + {4'b0, q_c};
      end
      jbs_pkg::DIV_6: begin
        d_c = 5'd6;
        qd_c = {2'b0, q_c, 2'b0} + {3'b0, q_c, 1'b0};
      end
      default: begin
        d_c = 5'd4;
        qd_c = '0;
      end
    endcase
    rem_c = {1'b0, mag2} - qd_c;
    if (t2.div == jbs_pkg::DIV_9 || t2.div == jbs_pkg::DIV_6) begin
      if (rem_c >= 28'(d_c)) q_c = q_c + 24'd1;
    end else begin
      q_c = 24'(mag2 >> 2);
    end
    if (t2.div == jbs_pkg::DIV_NONE) nv_c = t2.old;
    else nv_c = neg2 ? -$signed(q_c) : $signed(q_c);
  end

  always_comb begin
    diff_c = 25'(nv3) - 25'(t3.old);
    ad_c = diff_c[24] ? 24'(-diff_c) : 24'(diff_c);
    mx_c = (ad_c > run_max) ? ad_c : run_max;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1 <= sum_c;
      t1 <= '{req.old, req.div, req.row, req.col, req.frame_end, req.last_of_run};
      mag2 <= mag_c;
      neg2 <= sum1[27];
      prod2 <= 56'(mag_c) * 56'(recip_c);
      t2 <= t1;
      nv3 <= nv_c;
      t3 <= t2;
      if (v3) begin
        row_index <= t3.row[10:0];
        column_index <= t3.col[10:0];
        new_value <= nv3;
        abs_change <= ad_c;
        frame_max_change <= mx_c;
        converged <= t3.frame_end && (mx_c < target);
        frame_end <= t3.frame_end;
        last_of_run <= t3.last_of_run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
      run_max <= '0;
    end else begin
      if (en) begin
        v1 <= req_valid;
        v2 <= v1;
        v3 <= v2;
        out_valid <= v3;
        if (v3) run_max <= t3.frame_end ? 24'd0 : mx_c;
      end
      if (clear_max) run_max <= '0;
    end
  end

endmodule
